FILE: design/tlnf_pkg.sv
package tlnf_pkg;

    localparam int DIGITS  = 6;
    localparam int CNT_W   = 4 * DIGITS;
    localparam int DIG_W   = (DIGITS > 1) ? $clog2(DIGITS) : 1;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_NUMBER_MODE   = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SHOW_ENDS     = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SQUEEZE_BLANK = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SHOW_TABS     = 4'd3;

    localparam logic [1:0] MODE_NUM_OFF      = 2'd0;
    localparam logic [1:0] MODE_NUM_ALL      = 2'd1;
    localparam logic [1:0] MODE_NUM_NONBLANK = 2'd2;
    localparam logic [1:0] MODE_UNUSED       = 2'd3;

    localparam logic [7:0] BYTE_TAB    = 8'h09;
    localparam logic [7:0] BYTE_NL     = 8'h0A;
    localparam logic [7:0] BYTE_SPACE  = 8'h20;
    localparam logic [7:0] BYTE_DOLLAR = 8'h24;
    localparam logic [7:0] BYTE_ZERO   = 8'h30;
    localparam logic [7:0] BYTE_CARET  = 8'h5E;
    localparam logic [7:0] BYTE_CAP_I  = 8'h49;

    // one queued transaction, already classified
    typedef struct packed {
        logic [7:0]        ch;
        logic              num;
        logic              dpre;
        logic              caret;
        logic              dpost;
        logic [CNT_W-1:0]  bcd;
        logic [DIGITS-1:0] lead;
    } cmd_t;

    typedef struct packed {
        logic empty;
        logic full;
    } q_status_t;

endpackage

FILE: design/tlnf_front.sv
module tlnf_front
    import tlnf_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [7:0]            in_byte,
    input  logic                  file_end,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  q_status_t             q_status,
    output logic                  push,
    output cmd_t                  push_cmd
);

    logic [1:0]       number_mode_reg;
    logic             show_ends_reg;
    logic             squeeze_blank_reg;
    logic             show_tabs_reg;
    logic             at_line_start_reg;
    logic             at_line_start_next;
    logic             prev_blank_reg;
    logic             prev_blank_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [CNT_W-1:0] count_inc;

    logic accept;
    logic is_nl;
    logic blank;
    logic drop;
    logic emit_num;
    logic all_nines;
    logic carry;
    logic zero_above;
    logic [3:0] d;
    logic [DIGITS-1:0] lead_mask;

    assign cfg_ready = 1'b1;
    assign in_ready  = !q_status.full;
    assign accept    = in_valid && in_ready;

    assign is_nl    = (in_byte == BYTE_NL);
    assign blank    = at_line_start_reg && is_nl;
    assign drop     = squeeze_blank_reg && blank && prev_blank_reg;
    assign emit_num = at_line_start_reg
                      && ((number_mode_reg == MODE_NUM_ALL)
                          || ((number_mode_reg == MODE_NUM_NONBLANK) && !blank));

    // saturating bcd increment, ripple over the digits
    always_comb
    begin
        all_nines = 1'b1;
        carry     = 1'b1;
        count_inc = count_reg;
        for (int k = 0; k < DIGITS; k++)
        begin
            d = count_reg[4*k +: 4];
            if (d != 4'd9)
            begin
                all_nines = 1'b0;
            end
            if (carry)
            begin
                if (d >= 4'd9)
                begin
                    count_inc[4*k +: 4] = 4'd0;
                end
                else
                begin
                    count_inc[4*k +: 4] = d + 4'd1;
                    carry = 1'b0;
                end
            end
        end
        if (all_nines)
        begin
            count_inc = count_reg;
        end
    end

    // leading-space mask, digit 0 always printed
    always_comb
    begin
        zero_above = 1'b1;
        lead_mask  = '0;
        for (int k = DIGITS - 1; k >= 0; k--)
        begin
            if (count_reg[4*k +: 4] != 4'd0 || k == 0)
            begin
                zero_above = 1'b0;
            end
            lead_mask[k] = zero_above;
        end
    end

    assign push           = accept && !drop;
    assign push_cmd.ch    = in_byte;
    assign push_cmd.num   = emit_num;
    assign push_cmd.dpre  = is_nl && show_ends_reg;
    assign push_cmd.caret = !is_nl && show_tabs_reg && (in_byte == BYTE_TAB);
    assign push_cmd.dpost = !is_nl && file_end && show_ends_reg;
    assign push_cmd.bcd   = count_reg;
    assign push_cmd.lead  = lead_mask;

    always_comb
    begin
        at_line_start_next = at_line_start_reg;
        prev_blank_next    = prev_blank_reg;
        count_next         = count_reg;
        if (push)
        begin
            prev_blank_next    = squeeze_blank_reg && blank;
            at_line_start_next = is_nl ? 1'b1 : file_end;
            if (emit_num)
            begin
                count_next = count_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            number_mode_reg   <= '0;
            show_ends_reg     <= 1'b0;
            squeeze_blank_reg <= 1'b0;
            show_tabs_reg     <= 1'b0;
            at_line_start_reg <= 1'b1;
            prev_blank_reg    <= 1'b0;
            count_reg         <= CNT_W'(1);
        end
        else
        begin
            at_line_start_reg <= at_line_start_next;
            prev_blank_reg    <= prev_blank_next;
            count_reg         <= count_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    REG_NUMBER_MODE:   number_mode_reg   <= cfg_data[1:0];
                    REG_SHOW_ENDS:     show_ends_reg     <= cfg_data[0];
                    REG_SQUEEZE_BLANK: squeeze_blank_reg <= cfg_data[0];
                    REG_SHOW_TABS:     show_tabs_reg     <= cfg_data[0];
                    default:           ;
                endcase
            end
        end
    end

endmodule

FILE: design/tlnf_queue.sv
module tlnf_queue
    import tlnf_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  cmd_t      push_cmd,
    input  logic      pop,
    output cmd_t      head,
    output q_status_t status
);

    cmd_t       entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign head          = entry_reg[rd_ptr_reg];
    assign status.empty  = (count_reg == 2'd0);
    assign status.full   = (count_reg == 2'd2);

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

endmodule

FILE: design/tlnf_back.sv
module tlnf_back
    import tlnf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cmd_t       head,
    input  q_status_t  q_status,
    output logic       pop,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       last_of_run
);

    localparam logic [2:0] PH_DIGIT = 3'd0;
    localparam logic [2:0] PH_TAB   = 3'd1;
    localparam logic [2:0] PH_DPRE  = 3'd2;
    localparam logic [2:0] PH_CARET = 3'd3;
    localparam logic [2:0] PH_CAPI  = 3'd4;
    localparam logic [2:0] PH_BYTE  = 3'd5;
    localparam logic [2:0] PH_DPOST = 3'd6;
    localparam logic [2:0] PH_DONE  = 3'd7;

    logic             active_reg;
    logic [2:0]       phase_reg;
    logic [DIG_W-1:0] digit_reg;
    logic             out_valid_reg;
    logic [7:0]       out_byte_reg;
    logic             last_reg;

    logic [2:0]       after_prefix;
    logic [2:0]       cur_phase;
    logic [DIG_W-1:0] cur_digit;
    logic [2:0]       nxt_phase;
    logic [DIG_W-1:0] nxt_digit;
    logic [3:0]       dval;
    logic [7:0]       cur_byte;
    logic             cur_last;
    logic             step;

    assign after_prefix = head.dpre ? PH_DPRE : (head.caret ? PH_CARET : PH_BYTE);

    always_comb
    begin
        if (active_reg)
        begin
            cur_phase = phase_reg;
            cur_digit = digit_reg;
        end
        else
        begin
            cur_phase = head.num ? PH_DIGIT : after_prefix;
            cur_digit = DIG_W'(DIGITS - 1);
        end
    end

    always_comb
    begin
        dval = head.bcd[4*cur_digit +: 4];
        if (dval > 4'd9)
        begin
            dval = 4'd9;
        end
    end

    always_comb
    begin
        nxt_digit = cur_digit;
        cur_byte  = head.ch;
        unique case (cur_phase)
            PH_DIGIT:
            begin
                cur_byte  = head.lead[cur_digit] ? BYTE_SPACE : (BYTE_ZERO + {4'd0, dval});
                nxt_phase = (cur_digit == '0) ? PH_TAB : PH_DIGIT;
                nxt_digit = cur_digit - DIG_W'(1);
            end
            PH_TAB:
            begin
                cur_byte  = BYTE_TAB;
                nxt_phase = after_prefix;
            end
            PH_DPRE:
            begin
                cur_byte  = BYTE_DOLLAR;
                nxt_phase = PH_BYTE;
            end
            PH_CARET:
            begin
                cur_byte  = BYTE_CARET;
                nxt_phase = PH_CAPI;
            end
            PH_CAPI:
            begin
                cur_byte  = BYTE_CAP_I;
                nxt_phase = head.dpost ? PH_DPOST : PH_DONE;
            end
            PH_BYTE:
            begin
                cur_byte  = head.ch;
                nxt_phase = head.dpost ? PH_DPOST : PH_DONE;
            end
            PH_DPOST:
            begin
                cur_byte  = BYTE_DOLLAR;
                nxt_phase = PH_DONE;
            end
            default:
            begin
                nxt_phase = PH_DONE;
            end
        endcase
    end

    assign cur_last = (nxt_phase == PH_DONE);
    assign step     = !q_status.empty && (!out_valid_reg || out_ready);
    assign pop      = step && cur_last;

    assign out_valid   = out_valid_reg;
    assign out_byte    = out_byte_reg;
    assign last_of_run = last_reg;

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            out_byte_reg <= cur_byte;
            last_reg     <= cur_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            phase_reg     <= PH_DIGIT;
            digit_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (step)
            begin
                out_valid_reg <= 1'b1;
                active_reg    <= !cur_last;
                phase_reg     <= nxt_phase;
                digit_reg     <= nxt_digit;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

FILE: design/text_line_number_filter.sv
// channel | direction | handshake             | payload
// input   | in        | in_valid / in_ready   | in_byte, file_end
// output  | out       | out_valid / out_ready | out_byte, last_of_run
// config  | in        | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// the back end emits one output byte per cycle unless the queue is empty or out_ready stalls it;
// a transaction makes 1 byte for a plain byte, up to 10 with a line number prefix
// a two-entry command queue sits between front and back, input stalls only when full
// a squeezed blank line is absorbed by the front and makes no output
// reset clears the queue, output valid, options and line state, count starts at 1
module text_line_number_filter
    import tlnf_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [7:0]            in_byte,
    input  logic                  file_end,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [7:0]            out_byte,
    output logic                  last_of_run,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    q_status_t q_status;
    logic      push;
    logic      pop;
    cmd_t      push_cmd;
    cmd_t      head;

    tlnf_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_byte   (in_byte),
        .file_end  (file_end),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_status  (q_status),
        .push      (push),
        .push_cmd  (push_cmd)
    );

    tlnf_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .status   (q_status)
    );

    tlnf_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head),
        .q_status    (q_status),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_byte    (out_byte),
        .last_of_run (last_of_run)
    );

endmodule
